/* hw/rtl/lfps_pkg.sv */
// Shared constants, types and codes for the line-follow PID steering block.
package lfps_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int MOTOR_LIMIT_DEF = 100;

  localparam int CMD_W   = 2;
  localparam int BASE_W  = 7;
  localparam int GAIN_W  = 8;
  localparam int SUM_W   = 24;
  localparam int CORR_W  = 16;
  localparam int DRIVE_W = 8;

  localparam int PERCENT    = 100;
  localparam int DARK_START = 999;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRACK   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } lfps_cmd_t;

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2,
    REG_MODE  = 2'd3
  } lfps_reg_t;

endpackage

/* hw/rtl/lfps_if.sv */
// Valid/ready channel interfaces for the steering block's items and results.
interface lfps_in_if #(
  parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [lfps_pkg::CMD_W-1:0]     cmd;
  logic [SAMPLE_BITS-1:0]         light_sample;
  logic [lfps_pkg::BASE_W-1:0]    base_speed;

  modport source (output valid, output cmd, output light_sample, output base_speed,
                  input ready);
  modport sink   (input valid, input cmd, input light_sample, input base_speed,
                  output ready);
endinterface

interface lfps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lfps_pkg::DRIVE_W-1:0] left_drive;
  logic signed [lfps_pkg::DRIVE_W-1:0] right_drive;
  logic signed [lfps_pkg::CORR_W-1:0]  correction;
  logic                                width_zero;
  logic                                saturated;

  modport source (output valid, output left_drive, output right_drive, output correction,
                  output width_zero, output saturated, input ready);
  modport sink   (input valid, input left_drive, input right_drive, input correction,
                  input width_zero, input saturated, output ready);
endinterface

/* hw/rtl/line_follow_pid_steer.sv */
// Top level: bound tracking, width-normalized PID steering and motor clamping.
// A control item passes S_PREP, the divider wait S_DIV, S_MUL_P/I/D, S_ACC, S_FIN and S_DRIVE;
// S_DIV is skipped when the bound width is zero, and a tracking item goes straight to S_DRIVE.
// The radix-4 divider is the longest step; the three gain products share one multiplier.
// One item is in work at a time; the next is taken the cycle after the result is registered,
// even while that result still waits in the output register.
// Synchronous active-low reset restores the register defaults, bounds 999/0 and clears PID state.
module line_follow_pid_steer #(
  parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF,
  parameter int MOTOR_LIMIT = lfps_pkg::MOTOR_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lfps_in_if.sink                     in_item,
  lfps_out_if.source                  out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfps_pkg::APB_AW-1:0] paddr,
  input  logic [lfps_pkg::APB_DW-1:0] pwdata,
  output logic [lfps_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int SW   = SAMPLE_BITS;
  localparam int EW   = SW + 1;
  localparam int DWN  = SW + 7;
  localparam int PTW  = DWN + 1;
  localparam int DRW  = SW + 2;
  localparam int MAW  = (PTW > lfps_pkg::SUM_W) ? PTW : lfps_pkg::SUM_W;
  localparam int PRW  = MAW + lfps_pkg::GAIN_W + 1;
  localparam int ACW  = PRW + 2;
  localparam int DXW  = lfps_pkg::CORR_W + 2;
  localparam int SMAX = (1 << SW) - 1;
  localparam int DRST = (lfps_pkg::DARK_START > SMAX) ? SMAX : lfps_pkg::DARK_START;
  localparam int GW   = lfps_pkg::GAIN_W;
  localparam int CRW  = lfps_pkg::CORR_W;
  localparam int SUMW = lfps_pkg::SUM_W;
  localparam int DVW  = lfps_pkg::DRIVE_W;

  localparam logic [SW-1:0]         DARK_RST = SW'(DRST);
  localparam logic signed [DXW-1:0] MLIM     = DXW'(MOTOR_LIMIT);
  localparam logic signed [DVW-1:0] MLIM_OUT = DVW'(MOTOR_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_MUL_P, S_MUL_I, S_MUL_D, S_ACC, S_FIN, S_DRIVE
  } state_t;

  state_t                         state_r;
  logic [GW-1:0]                  prop_r, integ_r, deriv_gain_r;
  logic                           mode_r;
  logic [SW-1:0]                  dark_r, white_r;
  logic signed [SUMW-1:0]         sum_r;
  logic signed [EW-1:0]           prev_r;
  logic signed [EW-1:0]           err_r;
  logic signed [DRW-1:0]          deriv_r;
  logic [lfps_pkg::BASE_W-1:0]    base_r;
  logic                           track_r;
  logic                           wzero_r;
  logic                           sat_r;
  logic signed [PTW-1:0]          pterm_r;
  logic signed [PRW-1:0]          prod_r;
  logic signed [ACW-1:0]          acc_r;
  logic signed [CRW-1:0]          corr_r;
  logic                           out_valid_r;
  logic signed [DVW-1:0]          out_left_r, out_right_r;
  logic signed [CRW-1:0]          out_corr_r;
  logic                           out_wzero_r, out_sat_r;

  logic                           in_acc;
  logic                           cfg_wr;
  logic                           is_step;
  logic [SW-1:0]                  samp;
  logic [SW:0]                    bsum;
  logic [SW-1:0]                  setp;
  logic signed [EW-1:0]           err_new;
  logic [SW-1:0]                  width;
  logic [EW-1:0]                  err_neg;
  logic [SW-1:0]                  err_mag;
  logic [DWN-1:0]                 div_num;
  logic                           div_start;
  logic [DWN-1:0]                 div_quo;
  logic                           div_done;
  logic signed [PTW-1:0]          q_s;
  logic signed [SUMW:0]           sum_wide;
  logic                           sum_ovf;
  logic signed [MAW-1:0]          mul_a;
  logic [GW-1:0]                  mul_g;
  logic signed [PRW-1:0]          mul_p;
  logic [ACW-CRW:0]               acc_top;
  logic                           corr_ovf;
  logic signed [CRW-1:0]          corr_sat;
  logic signed [DXW-1:0]          base_x, corr_x, sum_plus, sum_minus;
  logic                           out_free;

  function automatic logic signed [DVW-1:0] clamp_drive(input logic signed [DXW-1:0] v);
    if (v > MLIM) begin
      return DVW'(MLIM);
    end else if (v < -MLIM) begin
      return DVW'(-MLIM);
    end else begin
      return DVW'(v);
    end
  endfunction

  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;
  assign cfg_wr        = psel && penable && pwrite;
  assign pready        = 1'b1;
  assign out_free      = !out_valid_r || out_item.ready;

  always_comb begin
    unique case (lfps_pkg::lfps_reg_t'(paddr[3:2]))
      lfps_pkg::REG_PROP:  prdata = lfps_pkg::APB_DW'(prop_r);
      lfps_pkg::REG_INTEG: prdata = lfps_pkg::APB_DW'(integ_r);
      lfps_pkg::REG_DERIV: prdata = lfps_pkg::APB_DW'(deriv_gain_r);
      lfps_pkg::REG_MODE:  prdata = lfps_pkg::APB_DW'(mode_r);
      default:             prdata = '0;
    endcase
  end

  // The set point comes from the bounds as they stood before this sample.
  always_comb begin
    samp    = in_item.light_sample;
    is_step = (in_item.cmd == lfps_pkg::CMD_STEP) || (in_item.cmd == lfps_pkg::CMD_RESTART);
    bsum    = {1'b0, white_r} + {1'b0, dark_r};
    setp    = bsum[SW:1];
    err_new = $signed({1'b0, samp}) - $signed({1'b0, setp});
  end

  always_comb begin
    width     = white_r - dark_r;
    err_neg   = -err_r;
    err_mag   = err_r[EW-1] ? err_neg[SW-1:0] : err_r[SW-1:0];
    div_num   = DWN'(err_mag) * DWN'(lfps_pkg::PERCENT);
    div_start = (state_r == S_PREP) && (width != '0);
    q_s       = $signed({1'b0, div_quo});
    sum_wide  = (SUMW + 1)'(sum_r) + (SUMW + 1)'(err_r);
    sum_ovf   = (sum_wide[SUMW] != sum_wide[SUMW-1]);
  end

  // Shared multiplier: one gain product per cycle, registered before accumulation.
  always_comb begin
    case (state_r)
      S_MUL_P: begin
        mul_a = MAW'(pterm_r);
        mul_g = prop_r;
      end
      S_MUL_I: begin
        mul_a = MAW'(sum_r);
        mul_g = integ_r;
      end
      default: begin
        mul_a = MAW'(deriv_r);
        mul_g = deriv_gain_r;
      end
    endcase
    mul_p = PRW'(mul_a) * PRW'($signed({1'b0, mul_g}));
  end

  always_comb begin
    acc_top   = acc_r[ACW-1:CRW-1];
    corr_ovf  = !((&acc_top) || (~|acc_top));
    corr_sat  = corr_ovf ? $signed({acc_r[ACW-1], {(CRW-1){~acc_r[ACW-1]}}})
                         : acc_r[CRW-1:0];
    base_x    = $signed(DXW'(base_r));
    corr_x    = DXW'(corr_r);
    sum_plus  = base_x + corr_x;
    sum_minus = base_x - corr_x;
  end

  lfps_div #(
    .DW (DWN),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (width),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prop_r       <= GW'(1);
      integ_r      <= '0;
      deriv_gain_r <= '0;
      mode_r       <= 1'b1;
      dark_r       <= DARK_RST;
      white_r      <= '0;
      sum_r        <= '0;
      prev_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (lfps_pkg::lfps_reg_t'(paddr[3:2]))
          lfps_pkg::REG_PROP:  prop_r       <= pwdata[GW-1:0];
          lfps_pkg::REG_INTEG: integ_r      <= pwdata[GW-1:0];
          lfps_pkg::REG_DERIV: deriv_gain_r <= pwdata[GW-1:0];
          lfps_pkg::REG_MODE:  mode_r       <= pwdata[0];
          default:             mode_r       <= mode_r;
        endcase
      end

      // S_DRIVE sets the valid flag itself when the output register frees up.
      if (out_valid_r && out_item.ready && (state_r != S_DRIVE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (samp < dark_r) begin
              dark_r <= samp;
            end
            if (samp > white_r) begin
              white_r <= samp;
            end
            err_r   <= err_new;
            base_r  <= in_item.base_speed;
            track_r <= !is_step;
            wzero_r <= 1'b0;
            sat_r   <= 1'b0;
            if (in_item.cmd == lfps_pkg::CMD_RESTART) begin
              sum_r  <= '0;
              prev_r <= '0;
            end
            state_r <= is_step ? S_PREP : S_DRIVE;
          end
        end
        S_PREP: begin
          if (sum_ovf) begin
            sum_r <= $signed({sum_wide[SUMW], {(SUMW-1){~sum_wide[SUMW]}}});
            sat_r <= 1'b1;
          end else begin
            sum_r <= sum_wide[SUMW-1:0];
          end
          deriv_r <= DRW'(prev_r) - DRW'(err_r);
          prev_r  <= err_r;
          if (width == '0) begin
            wzero_r <= 1'b1;
            pterm_r <= '0;
            state_r <= S_MUL_P;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pterm_r <= err_r[EW-1] ? -q_s : q_s;
            state_r <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          prod_r  <= mul_p;
          state_r <= S_MUL_I;
        end
        S_MUL_I: begin
          acc_r   <= ACW'(prod_r);
          prod_r  <= mul_p;
          state_r <= S_MUL_D;
        end
        S_MUL_D: begin
          acc_r   <= acc_r + ACW'(prod_r);
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + ACW'(prod_r);
          state_r <= S_FIN;
        end
        S_FIN: begin
          corr_r  <= corr_sat;
          sat_r   <= sat_r | corr_ovf;
          state_r <= S_DRIVE;
        end
        S_DRIVE: begin
          // Waits only while the previous result still sits in the output register.
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (track_r) begin
              out_left_r  <= '0;
              out_right_r <= '0;
              out_corr_r  <= '0;
              out_wzero_r <= 1'b0;
              out_sat_r   <= 1'b0;
            end else begin
              out_left_r  <= mode_r ? clamp_drive(sum_plus) : clamp_drive(sum_minus);
              out_right_r <= mode_r ? clamp_drive(sum_minus) : clamp_drive(sum_plus);
              out_corr_r  <= corr_r;
              out_wzero_r <= wzero_r;
              out_sat_r   <= sat_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.left_drive  = out_left_r;
  assign out_item.right_drive = out_right_r;
  assign out_item.correction  = out_corr_r;
  assign out_item.width_zero  = out_wzero_r;
  assign out_item.saturated   = out_sat_r;

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (dark_r <= white_r))
    else $error("dark bound above white bound after an item");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r <= MLIM_OUT && out_left_r >= -MLIM_OUT &&
                     out_right_r <= MLIM_OUT && out_right_r >= -MLIM_OUT))
    else $error("motor command outside its limit");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

endmodule

/* hw/rtl/lfps_div.sv */
// Unsigned restoring divider that retires two quotient bits per cycle.
module lfps_div #(
  parameter int DW = lfps_pkg::SAMPLE_BITS_DEF + 7,
  parameter int SW = lfps_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int STEPS = (DW + 1) / 2;
  localparam int PW    = 2 * STEPS;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] den_r;
  logic [PW-1:0] quo_r;

  logic [SW:0]   r1, r2;
  logic [SW:0]   r1_sub, r2_sub;
  logic          q1, q2;
  logic [SW-1:0] r1_keep, r2_keep;

  // quo_r shifts dividend bits out at the top and quotient bits in at the bottom.
  always_comb begin
    r1      = {rem_r, quo_r[PW-1]};
    r1_sub  = r1 - {1'b0, den_r};
    q1      = (r1 >= {1'b0, den_r});
    r1_keep = q1 ? r1_sub[SW-1:0] : r1[SW-1:0];
    r2      = {r1_keep, quo_r[PW-2]};
    r2_sub  = r2 - {1'b0, den_r};
    q2      = (r2 >= {1'b0, den_r});
    r2_keep = q2 ? r2_sub[SW-1:0] : r2[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS - 1);
        rem_r  <= '0;
        den_r  <= divisor;
        quo_r  <= PW'(dividend);
      end else if (busy_r) begin
        rem_r <= r2_keep;
        quo_r <= {quo_r[PW-3:0], q1, q2};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r[DW-1:0];
  assign done     = done_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !start) |=> (done_r && !busy_r))
    else $error("divider missed its last step");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the line-follow PID steering block.
module tb;

  localparam int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF;
  localparam int GW = lfps_pkg::GAIN_W;
  localparam logic [lfps_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam longint SUM_MAX = (longint'(1) << (lfps_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) << (lfps_pkg::SUM_W - 1));
  localparam longint CORR_MAX = (longint'(1) << (lfps_pkg::CORR_W - 1)) - 1;
  localparam longint CORR_MIN = -(longint'(1) << (lfps_pkg::CORR_W - 1));
  localparam longint MOTOR_MAX = lfps_pkg::MOTOR_LIMIT_DEF;
  localparam int RANDOM_ITEMS = 1740;

  typedef struct packed {
    logic [lfps_pkg::CMD_W-1:0]  cmd;
    logic [SAMPLE_BITS-1:0]      sample;
    logic [lfps_pkg::BASE_W-1:0] base;
  } light_item_t;

  typedef struct packed {
    logic signed [lfps_pkg::DRIVE_W-1:0] left_drive;
    logic signed [lfps_pkg::DRIVE_W-1:0] right_drive;
    logic signed [lfps_pkg::CORR_W-1:0]  correction;
    logic                                width_zero;
    logic                                saturated;
  } steer_t;

  logic clk;
  logic rst_n;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lfps_pkg::APB_AW-1:0] paddr = '0;
  logic [lfps_pkg::APB_DW-1:0] pwdata = '0;
  logic [lfps_pkg::APB_DW-1:0] prdata;
  logic pready;

  lfps_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  lfps_out_if out_ch ();

  line_follow_pid_steer #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MOTOR_LIMIT(lfps_pkg::MOTOR_LIMIT_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the block's registers and tracking/PID state.
  logic [GW-1:0]                     kp, ki, kd;
  logic                              left_edge;
  logic [SAMPLE_BITS-1:0]            dark_lvl, white_lvl;
  logic signed [lfps_pkg::SUM_W-1:0] err_sum;
  logic signed [SAMPLE_BITS:0]       last_err;

  light_item_t light_queue[$];
  steer_t      steer_queue[$];
  light_item_t offer;
  steer_t      want;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pick = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned rnd_done = 0;
  int unsigned tick = 0;
  bit          calm = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #120000000;
    $display("[line_follow_pid_steer] ERROR");
    $finish;
  end

  function automatic steer_t predict_steer(input light_item_t it);
    steer_t r;
    longint s, b, mid, err, wd, pterm, dev, sum, corr, l, rt;
    logic hit;
    r = '0;
    hit = 1'b0;
    s = longint'(it.sample);
    b = longint'(it.base);
    // The set point comes from the bounds as they stood before this sample.
    mid = (longint'(white_lvl) + longint'(dark_lvl)) / 2;
    if (it.sample < dark_lvl) dark_lvl = it.sample;
    if (it.sample > white_lvl) white_lvl = it.sample;
    if (it.cmd != lfps_pkg::CMD_STEP && it.cmd != lfps_pkg::CMD_RESTART) return r;
    if (it.cmd == lfps_pkg::CMD_RESTART) begin
      err_sum = '0;
      last_err = '0;
    end
    err = s - mid;
    wd = longint'(white_lvl) - longint'(dark_lvl);
    if (wd == 0) begin
      r.width_zero = 1'b1;
      pterm = 0;
    end else begin
      pterm = (err * lfps_pkg::PERCENT) / wd;
    end
    sum = longint'(err_sum) + err;
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
      hit = 1'b1;
    end else if (sum < SUM_MIN) begin
      sum = SUM_MIN;
      hit = 1'b1;
    end
    err_sum = sum[lfps_pkg::SUM_W-1:0];
    dev = longint'(last_err) - err;
    corr = longint'(kp) * pterm + longint'(ki) * sum + longint'(kd) * dev;
    if (corr > CORR_MAX) begin
      corr = CORR_MAX;
      hit = 1'b1;
    end else if (corr < CORR_MIN) begin
      corr = CORR_MIN;
      hit = 1'b1;
    end
    if (left_edge) begin
      l = b + corr;
      rt = b - corr;
    end else begin
      l = b - corr;
      rt = b + corr;
    end
    if (l > MOTOR_MAX) l = MOTOR_MAX;
    if (l < -MOTOR_MAX) l = -MOTOR_MAX;
    if (rt > MOTOR_MAX) rt = MOTOR_MAX;
    if (rt < -MOTOR_MAX) rt = -MOTOR_MAX;
    last_err = err[SAMPLE_BITS:0];
    r.left_drive = l[lfps_pkg::DRIVE_W-1:0];
    r.right_drive = rt[lfps_pkg::DRIVE_W-1:0];
    r.correction = corr[lfps_pkg::CORR_W-1:0];
    r.saturated = hit;
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones; none during calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 15);
    if (roll == 0) return $urandom_range(10, 40);
    if (roll <= 3) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tick <= tick + 1;
    if (tick[8:0] == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Sender: offers queued items, with a random gap, often none, after each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) steer_queue.push_back(predict_steer(offer));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (light_queue.size() != 0) begin
          offer = light_queue.pop_front();
          in_ch.cmd <= offer.cmd;
          in_ch.light_sample <= offer.sample;
          in_ch.base_speed <= offer.base;
          in_ch.valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (steer_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, got correction %0d", $time,
                   out_ch.correction);
          mismatches++;
        end else begin
          want = steer_queue.pop_front();
          check_field("left_drive", want.left_drive, out_ch.left_drive);
          check_field("right_drive", want.right_drive, out_ch.right_drive);
          check_field("correction", want.correction, out_ch.correction);
          check_field("width_zero", want.width_zero, out_ch.width_zero);
          check_field("saturated", want.saturated, out_ch.saturated);
        end
      end
      // One long hold-off so the block fills up and backs up its input.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_pick = pick_gap();
        out_ch.ready <= (stall_pick == 0);
        if (stall_pick != 0) stall_left <= stall_pick - 1;
      end
    end
  end

  task automatic write_reg(input lfps_pkg::lfps_reg_t idx,
                           input logic [lfps_pkg::APB_DW-1:0] val);
    logic [lfps_pkg::APB_DW-1:0] exp_rd;
    logic [lfps_pkg::APB_DW-1:0] got_rd;
    exp_rd = '0;
    case (idx)
      lfps_pkg::REG_PROP:  begin kp = val[GW-1:0]; exp_rd[GW-1:0] = kp; end
      lfps_pkg::REG_INTEG: begin ki = val[GW-1:0]; exp_rd[GW-1:0] = ki; end
      lfps_pkg::REG_DERIV: begin kd = val[GW-1:0]; exp_rd[GW-1:0] = kd; end
      lfps_pkg::REG_MODE:  begin left_edge = val[0]; exp_rd[0] = left_edge; end
      default: ;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got_rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got_rd !== exp_rd) begin
      $display("%0t register %s readback: expected %0h, got %0h", $time, idx.name(),
               exp_rd, got_rd);
      mismatches++;
    end
  endtask

  // Upper bits carry junk; the block keeps only the register's own width.
  task automatic set_gains(input logic [GW-1:0] p, input logic [GW-1:0] i,
                           input logic [GW-1:0] d, input logic m);
    logic [lfps_pkg::APB_DW-1:0] junk;
    junk = $urandom;
    write_reg(lfps_pkg::REG_PROP, {junk[lfps_pkg::APB_DW-1:GW], p});
    write_reg(lfps_pkg::REG_INTEG, {junk[lfps_pkg::APB_DW-1:GW], i});
    write_reg(lfps_pkg::REG_DERIV, {junk[lfps_pkg::APB_DW-1:GW], d});
    write_reg(lfps_pkg::REG_MODE, {junk[lfps_pkg::APB_DW-1:1], m});
  endtask

  task automatic push_item(input logic [lfps_pkg::CMD_W-1:0] c, input int s, input int b);
    light_item_t it;
    it.cmd = c;
    it.sample = s[SAMPLE_BITS-1:0];
    it.base = b[lfps_pkg::BASE_W-1:0];
    light_queue.push_back(it);
  endtask

  // The sample window starts narrow around the first bounds and widens to nearly the full range,
  // so the divider sees many small widths before the bounds saturate.
  task automatic push_random(input int n);
    int win, s, roll;
    logic [lfps_pkg::CMD_W-1:0] c;
    repeat (n) begin
      win = 1 + (rnd_done * 520) / RANDOM_ITEMS;
      s = 500 + int'($urandom_range(0, 2 * win)) - win;
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      if (rnd_done > 900 && $urandom_range(0, 15) == 0) s = $urandom_range(0, 1023);
      roll = $urandom_range(0, 19);
      if (roll <= 1) c = lfps_pkg::CMD_TRACK;
      else if (roll == 2) c = CMD_SPARE;
      else if (roll <= 4) c = lfps_pkg::CMD_RESTART;
      else c = lfps_pkg::CMD_STEP;
      push_item(c, s, $urandom_range(0, 127));
      rnd_done++;
    end
  endtask

  task automatic drain();
    while (light_queue.size() != 0 || in_ch.valid || steer_queue.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = lfps_pkg::CMD_TRACK;
    in_ch.light_sample = '0;
    in_ch.base_speed = '0;
    out_ch.ready = 1'b0;
    kp = 1;
    ki = 0;
    kd = 0;
    left_edge = 1'b1;
    dark_lvl = SAMPLE_BITS'(lfps_pkg::DARK_START);
    white_lvl = '0;
    err_sum = '0;
    last_err = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero width right after reset, spare command, base speed above range.
    push_item(lfps_pkg::CMD_STEP, 500, 50);
    push_item(lfps_pkg::CMD_RESTART, 500, 0);
    push_item(CMD_SPARE, 501, 127);
    push_item(lfps_pkg::CMD_TRACK, 499, 100);
    push_item(lfps_pkg::CMD_STEP, 501, 127);
    push_item(lfps_pkg::CMD_STEP, 499, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_gains(GW'($urandom_range(0, 15)), GW'($urandom_range(0, 3)),
                     GW'($urandom_range(0, 15)), 1'b0);
        2: set_gains(8'hFF, 8'hFF, 8'hFF, 1'b1);
        3: set_gains(8'h00, 8'h00, 8'h00, 1'b0);
        4: set_gains(GW'($urandom_range(0, 255)), GW'($urandom_range(0, 255)),
                     GW'($urandom_range(0, 255)), ($urandom_range(0, 1) != 0));
        5: set_gains(GW'($urandom_range(0, 7)), 8'h01, GW'($urandom_range(0, 7)),
                     ($urandom_range(0, 1) != 0));
        default: ;
      endcase
      push_random(RANDOM_ITEMS / 6);
      drain();
    end

    // Sample extremes at full gain: the correction clamps both ways.
    set_gains(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_item(lfps_pkg::CMD_STEP, 0, 127);
    push_item(lfps_pkg::CMD_STEP, 1023, 0);
    push_item(lfps_pkg::CMD_RESTART, 1023, 100);
    push_item(lfps_pkg::CMD_TRACK, 0, 0);
    push_item(CMD_SPARE, 1023, 127);
    push_item(lfps_pkg::CMD_STEP, 512, 127);
    drain();

    // Zero gains: a step at the extremes leaves the correction at zero.
    set_gains(8'h00, 8'h00, 8'h00, 1'b1);
    push_item(lfps_pkg::CMD_TRACK, 0, 10);
    push_item(lfps_pkg::CMD_TRACK, 1023, 10);
    push_item(lfps_pkg::CMD_RESTART, 1023, 40);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[line_follow_pid_steer] OK");
    end else begin
      $display("[line_follow_pid_steer] ERROR");
    end
    $finish;
  end

endmodule
